// File: sv/twi_pkg.sv
// Package for the table waveshaper: request/result structs, command codes,
// register map and reset values. No dependencies.
`timescale 1ns / 1ps

package twi_pkg;

  // Command codes carried by an input request
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register map (index = paddr[2])
  localparam int unsigned APB_AW     = 3;
  localparam logic        REG_GAIN   = 1'b0;
  localparam logic        REG_ENTRIES = 1'b1;

  localparam logic [15:0] GAIN_RESET    = 16'd4096;
  localparam logic [8:0]  ENTRIES_RESET = 9'd256;

  // Input request: a table load or a sample to shape
  typedef struct packed {
    logic               command;
    logic [7:0]         entry_index;
    logic signed [15:0] entry_value;
    logic signed [15:0] sample_in;
    logic               block_end;
  } twi_req_t;

  // Shaped result
  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               block_end_out;
  } twi_rsp_t;

endpackage

// File: sv/twi_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. No dependencies.
`timescale 1ns / 1ps

module twi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/table_waveshaper_interp.sv
// Top level of the table waveshaper with linear interpolation.
// Uses twi_pkg (types, codes) and twi_ram (two copies of the shape table).
`timescale 1ns / 1ps

// Channel  Direction  Handshake                   Payload
// in       in         in_valid_i / in_stall_o     in_req_i  (twi_req_t)
// out      out        out_valid_o / out_stall_i   out_rsp_o (twi_rsp_t)
// cfg      in         APB psel/penable/pwrite     drive_gain, entries_in_use
//
// Seven register stages: input, gain multiply, clamp, position multiply,
// table read, interpolation multiply, output. An accepted request passes
// through them in that order, and one request enters per cycle while the
// input is not stalled.
// The table is kept twice (one read port each) so both neighbor entries are
// read in the same cycle; loads write it at the same stage that samples read it.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles close up. Reset clears valid bits and configuration registers;
// the table contents stay undefined until loaded.
module table_waveshaper_interp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  twi_pkg::twi_req_t         in_req_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output twi_pkg::twi_rsp_t         out_rsp_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [twi_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import twi_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned NRST = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] gain_q;
  logic [8:0]  entries_q;
  logic [8:0]  n_eff;
  logic [8:0]  m_q;
  logic        cfg_we;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      entries_q <= ENTRIES_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_GAIN:    gain_q    <= pwdata[15:0];
        REG_ENTRIES: entries_q <= pwdata[8:0];
        default:     ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_GAIN:    prdata = {16'd0, gain_q};
      REG_ENTRIES: prdata = {23'd0, entries_q};
      default:     prdata = '0;
    endcase
  end

  // Limit the entry count to 2 .. TABLE_DEPTH and keep m = count - 1
  always_comb begin
    n_eff = entries_q;
    if (entries_q < 9'd2) begin
      n_eff = 9'd2;
    end else if (32'(entries_q) > TABLE_DEPTH) begin
      n_eff = 9'(TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= 9'(NRST - 1);
    end else begin
      m_q <= n_eff - 9'd1;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic [6:1] v_q;
  logic [7:1] rdy;
  logic       out_valid_q;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    rdy[7] = !out_valid_q || !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  twi_req_t s1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) s1_q <= in_req_i;
  end

  // ---------------------------------------------------------------------
  // Stage 2: sample times Q4.12 gain (Q5.27)
  // ---------------------------------------------------------------------
  logic               s2_cmd_q, s2_be_q;
  logic [7:0]         s2_eidx_q;
  logic signed [15:0] s2_eval_q;
  logic signed [32:0] s2_p_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_cmd_q  <= s1_q.command;
      s2_be_q   <= s1_q.block_end;
      s2_eidx_q <= s1_q.entry_index;
      s2_eval_q <= s1_q.entry_value;
      s2_p_q    <= 33'(s1_q.sample_in) * $signed({1'b0, gain_q});
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: floor shift, clamp to Q1.15, offset to 0 .. 65535
  // ---------------------------------------------------------------------
  logic signed [20:0] x_full;
  logic        [15:0] x_sat;
  logic               s3_cmd_q, s3_be_q;
  logic [7:0]         s3_eidx_q;
  logic signed [15:0] s3_eval_q;
  logic [15:0]        s3_u_q;

  assign x_full = s2_p_q[32:12];

  always_comb begin
    if (x_full > 21'sd32767) begin
      x_sat = 16'h7FFF;
    end else if (x_full < -21'sd32768) begin
      x_sat = 16'h8000;
    end else begin
      x_sat = x_full[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_be_q   <= s2_be_q;
      s3_eidx_q <= s2_eidx_q;
      s3_eval_q <= s2_eval_q;
      s3_u_q    <= {~x_sat[15], x_sat[14:0]};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: table position u * m (index in Q.16)
  // ---------------------------------------------------------------------
  logic               s4_cmd_q, s4_be_q;
  logic [7:0]         s4_eidx_q;
  logic signed [15:0] s4_eval_q;
  logic [24:0]        s4_pos_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_be_q   <= s3_be_q;
      s4_eidx_q <= s3_eidx_q;
      s4_eval_q <= s3_eval_q;
      s4_pos_q  <= 25'(s3_u_q) * 25'(m_q);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: table access; loads write, samples read both neighbors.
  // u stays below 2^16, so pos >> 16 never exceeds m - 1.
  // ---------------------------------------------------------------------
  logic [AW-1:0]      rd_addr0, rd_addr1, wr_addr;
  logic               ram_we;
  logic [15:0]        t0_rd, t1_rd;
  logic               s5_cmd_q, s5_be_q;
  logic [15:0]        s5_frac_q;

  assign rd_addr0 = AW'(s4_pos_q[24:16]);
  assign rd_addr1 = rd_addr0 + AW'(1);
  assign wr_addr  = AW'(s4_eidx_q);
  assign ram_we   = rdy[5] && v_q[4] && (s4_cmd_q == CMD_LOAD)
                    && (32'(s4_eidx_q) < TABLE_DEPTH);

  twi_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (s4_eval_q),
    .re_i    (rdy[5]),
    .raddr_i (rd_addr0),
    .rdata_o (t0_rd)
  );

  twi_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (s4_eval_q),
    .re_i    (rdy[5]),
    .raddr_i (rd_addr1),
    .rdata_o (t1_rd)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_cmd_q  <= s4_cmd_q;
      s5_be_q   <= s4_be_q;
      s5_frac_q <= s4_pos_q[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: frac * (t1 - t0)
  // ---------------------------------------------------------------------
  logic signed [16:0] diff;
  logic               s6_cmd_q, s6_be_q;
  logic signed [15:0] s6_t0_q;
  logic signed [33:0] s6_prod_q;

  assign diff = $signed({t1_rd[15], t1_rd}) - $signed({t0_rd[15], t0_rd});

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_cmd_q  <= s5_cmd_q;
      s6_be_q   <= s5_be_q;
      s6_t0_q   <= t0_rd;
      s6_prod_q <= $signed({1'b0, s5_frac_q}) * diff;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: t0 + floor(prod / 2^16) into the output register
  // ---------------------------------------------------------------------
  logic signed [17:0] y_sum;
  twi_rsp_t           out_rsp_q;

  assign y_sum = 18'(s6_t0_q) + s6_prod_q[33:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[7]) begin
      out_valid_q <= v_q[6] && (s6_cmd_q == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      out_rsp_q.sample_out    <= y_sum[15:0];
      out_rsp_q.block_end_out <= s6_be_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Input stalls only while stage 1 holds a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_q[1])
    else $error("input stalled with empty first stage");

  // A sample leaving stage 6 becomes a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy[7] && v_q[6] && (s6_cmd_q == CMD_SAMPLE) |=> out_valid_o)
    else $error("sample lost at output stage");

  // A load or bubble leaving stage 6 produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy[7] && !(v_q[6] && (s6_cmd_q == CMD_SAMPLE)) |=> !out_valid_o)
    else $error("result created without a sample");

  // Segment count stays at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (m_q != 9'd0))
    else $error("entry count limit broken");

endmodule

// File: dv/twi_shape_checker.sv
// Result checker for the table waveshaper: watches the request, result and
// configuration channels, predicts each shaped sample and compares. Uses twi_pkg.
`timescale 1ns / 1ps

module twi_shape_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  twi_pkg::twi_req_t            in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  twi_pkg::twi_rsp_t            out_rsp_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [twi_pkg::APB_AW-1:0]   paddr_i,
  input  logic [31:0]                  pwdata_i,
  output int unsigned                  mismatch_o,
  output int unsigned                  pending_o
);

  import twi_pkg::*;

  logic signed [15:0] shape_mem [DEPTH];
  logic [15:0]        gain_q;
  logic [8:0]         entries_q;
  twi_rsp_t           shaped_q [$];
  twi_rsp_t           want;

  initial mismatch_o = 0;
  initial pending_o  = 0;

  // Scale, clamp, locate the segment and interpolate between its two entries
  function automatic twi_rsp_t shape_sample(twi_req_t req);
    int       smp;
    int       gn;
    int       level;
    int       span;
    int       upos;
    int       seg;
    int       frac;
    int       lo;
    int       hi;
    longint   step;
    twi_rsp_t res;
    smp   = $signed(req.sample_in);
    gn    = gain_q;
    level = (smp * gn) >>> 12;
    if (level > 32767) level = 32767;
    else if (level < -32768) level = -32768;
    // clamp the entry count into the table, then count segments
    span = entries_q;
    if (span < 2) span = 2;
    else if (span > DEPTH) span = DEPTH;
    span = span - 1;
    upos = (level + 32768) * span;
    seg  = upos >> 16;
    if (seg > span - 1) seg = span - 1;
    frac = upos - (seg << 16);
    lo   = shape_mem[seg];
    hi   = shape_mem[seg + 1];
    step = longint'(frac) * longint'(hi - lo);
    res.sample_out    = 16'(lo + int'(step >>> 16));
    res.block_end_out = req.block_end;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shaped_q.delete();
      gain_q    = GAIN_RESET;
      entries_q = ENTRIES_RESET;
    end else begin
      // compare each delivered result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (shaped_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10)
            $display("%0t: unexpected result sample_out %0d block_end_out %0b", $time,
                     $signed(out_rsp_i.sample_out), out_rsp_i.block_end_out);
        end else begin
          want = shaped_q.pop_front();
          if (out_rsp_i.sample_out !== want.sample_out ||
              out_rsp_i.block_end_out !== want.block_end_out) begin
            mismatch_o++;
            if (mismatch_o <= 10)
              $display("%0t: mismatch expected sample_out %0d block_end_out %0b, got %0d %0b",
                       $time, $signed(want.sample_out), want.block_end_out,
                       $signed(out_rsp_i.sample_out), out_rsp_i.block_end_out);
          end
        end
      end
      // predict samples and track table loads in request order
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.command == CMD_SAMPLE)
          shaped_q.push_back(shape_sample(in_req_i));
        else if (in_req_i.entry_index < DEPTH)
          shape_mem[in_req_i.entry_index] = in_req_i.entry_value;
      end
      // follow register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_GAIN:    gain_q    = pwdata_i[15:0];
          REG_ENTRIES: entries_q = pwdata_i[8:0];
          default: ;
        endcase
      end
    end
    pending_o = shaped_q.size();
  end

endmodule

// File: dv/table_waveshaper_interp_tb.sv
// Testbench top for table_waveshaper_interp: fills the shape table, runs
// directed and random requests over several register settings with random
// idling, and gives the verdict. Uses twi_pkg and twi_shape_checker.
`timescale 1ns / 1ps

module table_waveshaper_interp_tb;
  import twi_pkg::*;

  localparam int unsigned PIPE_DEPTH  = 7;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_ITEMS = 153;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  twi_req_t            in_req;
  logic                out_valid;
  logic                out_stall;
  twi_rsp_t            out_rsp;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int unsigned         mismatch_cnt;
  int unsigned         pending_cnt;
  bit                  steady = 1'b0;

  int unsigned gain_set [PHASES] = '{4096, 65535, 0, 1, 8192, 4096, 49152, 0, 0};
  int unsigned count_set [PHASES] = '{256, 2, 256, 255, 17, 1, 0, 511, 0};

  table_waveshaper_interp i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  twi_shape_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .mismatch_o  (mismatch_cnt),
    .pending_o   (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // Stall the result channel in random bursts
  initial begin
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  // Bias a Q1.15 level toward the extremes and zero
  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      3: return 16'h8001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Fill every field at random, then set the command
  function automatic twi_req_t random_req(logic cmd);
    logic [63:0] bits;
    twi_req_t    req;
    bits = {$urandom, $urandom};
    req  = bits[$bits(twi_req_t)-1:0];
    req.command = cmd;
    return req;
  endfunction

  function automatic twi_req_t load_req(logic [7:0] idx, logic [15:0] val);
    twi_req_t req;
    req = random_req(CMD_LOAD);
    req.entry_index = idx;
    req.entry_value = val;
    return req;
  endfunction

  function automatic twi_req_t sample_req(logic [15:0] smp, logic last);
    twi_req_t req;
    req = random_req(CMD_SAMPLE);
    req.sample_in = smp;
    req.block_end = last;
    return req;
  endfunction

  // Hand one request over, with an optional idle gap first
  task automatic send_req(twi_req_t req);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Let every predicted result arrive and the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table so no sample reads an unwritten entry
    for (int i = 0; i < 256; i++) send_req(load_req(8'(i), pick_level()));

    // Directed: end entries at the extremes, edge samples, load then read at once
    send_req(load_req(8'd0, 16'h8000));
    send_req(sample_req(16'h8000, 1'b0));
    send_req(load_req(8'd255, 16'h7fff));
    send_req(load_req(8'd254, 16'h8000));
    send_req(sample_req(16'h7fff, 1'b1));
    send_req(sample_req(16'h7ffe, 1'b0));
    send_req(sample_req(16'h8001, 1'b1));
    send_req(sample_req(16'h0000, 1'b0));
    send_req(sample_req(16'hffff, 1'b1));
    send_req(sample_req(16'h0001, 1'b0));
    send_req(sample_req(16'h4000, 1'b0));
    send_req(sample_req(16'hc000, 1'b1));
    send_req(load_req(8'd128, 16'h7fff));
    send_req(load_req(8'd127, 16'h8000));
    send_req(sample_req(16'h0000, 1'b1));
    send_req(sample_req(16'h0080, 1'b0));

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph >= PHASES - 2) begin
        gain_set[ph]  = $urandom_range(0, 65535);
        count_set[ph] = $urandom_range(0, 511);
      end
      write_reg(REG_GAIN, 32'(gain_set[ph]));
      write_reg(REG_ENTRIES, 32'(count_set[ph]));
      steady = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_req(load_req(8'($urandom), pick_level()));
        else
          send_req(sample_req(pick_level(), 1'($urandom)));
      end
    end

    drain();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
